// File: sv/sfd_pkg.sv
package sfd_pkg;

  localparam logic [7:0] CH_OPEN   = 8'h3C;
  localparam logic [7:0] CH_STRING = 8'h40;
  localparam logic [7:0] CH_BINARY = 8'h21;
  localparam logic [7:0] CH_CLOSE  = 8'h3E;

  // bytes 1..15 are the only ones a result ever looks at
  localparam int PEEK_BYTES = 16;
  localparam int NUM_CODES  = 6;
  localparam int NUM_WORDS  = 6;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ECHO        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMU_REQUEST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMU_DATA    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_INPUT = 3'd5;

  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_ECHO        = 3'd1;
  localparam logic [2:0] ACT_LOG         = 3'd2;
  localparam logic [2:0] ACT_STATUS      = 3'd3;
  localparam logic [2:0] ACT_IMU_REQUEST = 3'd4;
  localparam logic [2:0] ACT_IMU_DATA    = 3'd5;
  localparam logic [2:0] ACT_STICK_INPUT = 3'd6;

  typedef struct packed {
    logic                            close;
    logic                            binary;
    logic                            cmd_valid;
    logic [7:0]                      cmd;
    logic [5:0]                      length;
    logic [NUM_WORDS-1:0][15:0]      words;
    logic                            link_clear;
  } sfd_info_t;

  function automatic logic [7:0] code_reset(input int idx);
    return 8'(idx + 1);
  endfunction

endpackage

// File: sv/serial_frame_deframer.sv
// serial_frame_deframer: finds '<' framed packets in a received byte stream
// byte channel: rx_byte with byte_valid / byte_stall, one byte per beat
// frame channel: one beat per closed frame, kind, command, matched action,
//   link flag, stored length and six big-endian payload words
// config port: cfg_we writes cfg_data into command code register cfg_index
//   (echo, log, status, imu request, imu data, stick input); write only when idle
// latency: a frame beat appears two cycles after the byte that closes it
//   (one cycle in the input register, one in the result register)
// throughput: one byte per cycle, set by the single input register feeding
//   the frame tracker and command match in one step
// reset: fill count and link flag cleared, command codes back to 1..6,
//   both registers empty
// stall on the frame channel holds the result; bytes keep flowing until a
//   byte waits in the input register, then byte_stall rises
module serial_frame_deframer #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_stall,
  input  logic [7:0]                    rx_byte,
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output logic                          frame_valid,
  input  logic                          frame_stall,
  output logic                          frame_kind,
  output logic [7:0]                    command,
  output logic [2:0]                    action,
  output logic                          connected,
  output logic [5:0]                    frame_length,
  output logic [15:0]                   word_a,
  output logic [15:0]                   word_b,
  output logic [15:0]                   word_c,
  output logic [15:0]                   word_d,
  output logic [15:0]                   word_e,
  output logic [15:0]                   word_f
);
  import sfd_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       step;
  logic       link_up;
  logic       link_next;
  logic [2:0] act;
  sfd_info_t  info;

  assign step       = in_full && (!frame_valid || !frame_stall);
  assign byte_stall = in_full && frame_valid && frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte <= rx_byte;
    end
  end

  sfd_tracker #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_tracker (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .info    (info)
  );

  sfd_match u_match (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .binary    (info.binary),
    .cmd_valid (info.cmd_valid),
    .cmd       (info.cmd),
    .action    (act)
  );

  always_comb begin
    link_next = link_up;
    if (info.link_clear) begin
      link_next = 1'b0;
    end else if (info.close) begin
      link_next = (act != ACT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_up <= 1'b0;
    end else if (step) begin
      link_up <= link_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (step && info.close) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && info.close) begin
      frame_kind   <= info.binary;
      command      <= info.cmd;
      action       <= act;
      connected    <= link_next;
      frame_length <= info.length;
      word_a       <= info.words[0];
      word_b       <= info.words[1];
      word_c       <= info.words[2];
      word_d       <= info.words[3];
      word_e       <= info.words[4];
      word_f       <= info.words[5];
    end
  end

  a_binary_len: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_kind |-> frame_length >= 6'd4)
    else $error("binary frame shorter than its header");

  a_link_matches_action: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> connected == (action != ACT_NONE))
    else $error("link flag disagrees with action");

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> in_full && frame_valid)
    else $error("byte stall without a waiting byte and frame");

endmodule

// File: sv/sfd_tracker.sv
module sfd_tracker #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output sfd_pkg::sfd_info_t info
);
  import sfd_pkg::*;

  localparam int FW = $clog2(BUFFER_DEPTH + 1);

  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic [FW-1:0] cnt;
  logic          wr_en;
  logic          close;
  logic          binary;
  logic          link_clear;
  logic [8:0]    cnt_w;
  logic [7:0]    store [1:PEEK_BYTES-1];
  logic [7:0]    view  [1:PEEK_BYTES-1];

  always_comb begin
    fill_next  = fill;
    cnt        = fill;
    wr_en      = 1'b0;
    close      = 1'b0;
    binary     = 1'b0;
    link_clear = 1'b0;
    priority if (fill == '0) begin
      if (rx_byte == CH_OPEN) begin
        fill_next = FW'(1);
      end
    end else if (fill == FW'(1)) begin
      if (rx_byte == CH_STRING || rx_byte == CH_BINARY) begin
        wr_en     = 1'b1;
        fill_next = FW'(2);
      end else begin
        fill_next  = '0;
        link_clear = 1'b1;
      end
    end else if (store[1] == CH_STRING && rx_byte == CH_CLOSE) begin
      close     = 1'b1;
      fill_next = '0;
    end else if (9'(fill) >= 9'(BUFFER_DEPTH)) begin
      fill_next = (rx_byte == CH_OPEN) ? FW'(1) : '0;
    end else begin
      wr_en     = 1'b1;
      cnt       = fill + FW'(1);
      fill_next = cnt;
      if (store[1] == CH_BINARY) begin
        if (cnt == FW'(3) && rx_byte < 8'd4) begin
          fill_next = '0;
        end else if (cnt >= FW'(4) && 9'(cnt) == 9'(store[2])) begin
          close     = 1'b1;
          binary    = 1'b1;
          fill_next = '0;
        end
      end
    end
  end

  // store contents as seen after this beat's write
  always_comb begin
    for (int i = 1; i < PEEK_BYTES; i++) begin
      view[i] = (wr_en && fill == FW'(i)) ? rx_byte : store[i];
    end
  end

  always_comb begin
    cnt_w           = 9'(cnt);
    info.close      = close;
    info.binary     = binary;
    info.link_clear = link_clear;
    info.cmd_valid  = binary || (fill >= FW'(3));
    if (binary) begin
      info.cmd = view[3];
    end else if (fill >= FW'(3)) begin
      info.cmd = view[2];
    end else begin
      info.cmd = 8'd0;
    end
    info.length = (cnt_w > 9'd63) ? 6'd63 : cnt_w[5:0];
    for (int k = 0; k < NUM_WORDS; k++) begin
      info.words[k][15:8] = (FW'(4 + 2 * k) < cnt) ? view[4 + 2 * k] : 8'd0;
      info.words[k][7:0]  = (FW'(5 + 2 * k) < cnt) ? view[5 + 2 * k] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (step) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      for (int i = 1; i < PEEK_BYTES; i++) begin
        if (fill == FW'(i)) begin
          store[i] <= rx_byte;
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    9'(fill) <= 9'(BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

  a_close_resets_fill: assert property (@(posedge clk) disable iff (rst)
    step && close |=> fill == '0)
    else $error("fill count not cleared after frame close");

endmodule

// File: sv/sfd_match.sv
module sfd_match (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          binary,
  input  logic                          cmd_valid,
  input  logic [7:0]                    cmd,
  output logic [2:0]                    action
);
  import sfd_pkg::*;

  logic [7:0] codes [NUM_CODES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        codes[i] <= code_reset(i);
      end
    end else if (cfg_we && 32'(cfg_index) < NUM_CODES) begin
      codes[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    priority if (!cmd_valid) begin
      action = ACT_NONE;
    end else if (binary) begin
      priority if (cmd == codes[CFG_IMU_REQUEST]) action = ACT_IMU_REQUEST;
      else if (cmd == codes[CFG_IMU_DATA]) action = ACT_IMU_DATA;
      else if (cmd == codes[CFG_ECHO]) action = ACT_ECHO;
      else if (cmd == codes[CFG_STICK_INPUT]) action = ACT_STICK_INPUT;
      else action = ACT_NONE;
    end else begin
      priority if (cmd == codes[CFG_ECHO]) action = ACT_ECHO;
      else if (cmd == codes[CFG_LOG]) action = ACT_LOG;
      else if (cmd == codes[CFG_STATUS]) action = ACT_STATUS;
      else action = ACT_NONE;
    end
  end

endmodule
